### hw/rtl/hsmc_pkg.sv
// hsmc_pkg: shared types and constants of the hard sphere move checker
// no dependencies; imported by hsmc_regs, hsmc_ctrl, hsmc_dpath and the top level
package hsmc_pkg;

	// request opcodes
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_MOVE   = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// register indexes on the config port
	localparam logic [2:0] REG_RADIUS = 3'd0;
	localparam logic [2:0] REG_X_LOW  = 3'd1;
	localparam logic [2:0] REG_X_HIGH = 3'd2;
	localparam logic [2:0] REG_Y_LOW  = 3'd3;
	localparam logic [2:0] REG_Y_HIGH = 3'd4;
	localparam logic [2:0] REG_Z_LOW  = 3'd5;
	localparam logic [2:0] REG_Z_HIGH = 3'd6;
	localparam logic [2:0] REG_COUNT  = 3'd7;

	// register reset values
	localparam logic [30:0] RADIUS_RST = 31'd65536;
	localparam logic [31:0] LOW_RST    = 32'd0;
	localparam logic [31:0] HIGH_RST   = 32'd655360;
	localparam logic [10:0] COUNT_RST  = 11'd1;

	// move arithmetic: 0.6 in signed q1.16 and the fraction clamp
	localparam logic signed [16:0] SIX_TENTHS = 17'sd39322;
	localparam logic signed [17:0] FRAC_ONE   = 18'sd65536;
	localparam logic signed [34:0] ROUND_HALF = 35'sd32768;

	localparam int NUM_AXES = 3;

	typedef enum logic [2:0] {
		RC_LOADED   = 3'd0,
		RC_ACCEPTED = 3'd1,
		RC_OUTSIDE  = 3'd2,
		RC_OVERLAP  = 3'd3,
		RC_READ     = 3'd4,
		RC_BAD      = 3'd5
	} rc_t;

	typedef enum logic [1:0] {
		OSEL_ZERO,
		OSEL_REQ,
		OSEL_OWN,
		OSEL_NEW
	} osel_t;

	typedef struct packed {
		logic [30:0]                   radius;
		logic [NUM_AXES-1:0][31:0]     box_low;
		logic [NUM_AXES-1:0][31:0]     box_high;
		logic [10:0]                   count;
	} cfg_t;

	typedef struct packed {
		logic  capture;
		logic  rd_own;
		logic  own_ld;
		logic  new_ld;
		logic  box_ld;
		logic  scan_clr;
		logic  scan_issue;
		logic  mem_wr;
		logic  wr_new;
		logic  out_ld;
		rc_t   code;
		osel_t sel;
	} cmd_t;

	typedef struct packed {
		logic       bad;
		logic [1:0] op;
		logic       in_box;
		logic       clash;
		logic       scan_last;
		logic       pipe_busy;
		logic       out_free;
	} stat_t;

endpackage

### hw/rtl/hsmc_regs.sv
// hsmc_regs: apb-style configuration registers of the move checker
// depends on hsmc_pkg for the register indexes, reset values and cfg_t
module hsmc_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output hsmc_pkg::cfg_t     cfg
);
	import hsmc_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[4:2];
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius   <= RADIUS_RST;
			cfg_q.box_low  <= {NUM_AXES{LOW_RST}};
			cfg_q.box_high <= {NUM_AXES{HIGH_RST}};
			cfg_q.count    <= COUNT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_RADIUS: cfg_q.radius      <= pwdata[30:0];
				REG_X_LOW:  cfg_q.box_low[0]  <= pwdata;
				REG_X_HIGH: cfg_q.box_high[0] <= pwdata;
				REG_Y_LOW:  cfg_q.box_low[1]  <= pwdata;
				REG_Y_HIGH: cfg_q.box_high[1] <= pwdata;
				REG_Z_LOW:  cfg_q.box_low[2]  <= pwdata;
				REG_Z_HIGH: cfg_q.box_high[2] <= pwdata;
				REG_COUNT:  cfg_q.count       <= pwdata[10:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RADIUS: prdata = {1'b0, cfg_q.radius};
			REG_X_LOW:  prdata = cfg_q.box_low[0];
			REG_X_HIGH: prdata = cfg_q.box_high[0];
			REG_Y_LOW:  prdata = cfg_q.box_low[1];
			REG_Y_HIGH: prdata = cfg_q.box_high[1];
			REG_Z_LOW:  prdata = cfg_q.box_low[2];
			REG_Z_HIGH: prdata = cfg_q.box_high[2];
			REG_COUNT:  prdata = {21'd0, cfg_q.count};
		endcase
	end

endmodule

### hw/rtl/hsmc_ctrl.sv
// hsmc_ctrl: controller state machine of the move checker
// depends on hsmc_pkg for cmd_t, stat_t, opcodes and result codes
module hsmc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  hsmc_pkg::stat_t stat,
	output hsmc_pkg::cmd_t  cmd
);
	import hsmc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_RD_WAIT,
		S_MV_OWN,
		S_MV_NEW,
		S_MV_BOX,
		S_MV_TEST,
		S_SCAN,
		S_DRAIN,
		S_RESP
	} state_t;

	state_t state_q;
	rc_t    code_q;
	osel_t  sel_q;
	logic   wr_q;
	logic   wr_new_q;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.code       = code_q;
		cmd.sel        = sel_q;
		cmd.wr_new     = wr_new_q;
		cmd.capture    = (state_q == S_IDLE) && req_valid;
		cmd.rd_own     = (state_q == S_DECODE);
		cmd.own_ld     = (state_q == S_RD_WAIT) || (state_q == S_MV_OWN);
		cmd.new_ld     = (state_q == S_MV_NEW);
		cmd.box_ld     = (state_q == S_MV_BOX);
		cmd.scan_clr   = (state_q == S_MV_TEST);
		cmd.scan_issue = (state_q == S_SCAN);
		cmd.out_ld     = (state_q == S_RESP) && stat.out_free;
		cmd.mem_wr     = (state_q == S_RESP) && stat.out_free && wr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			code_q   <= RC_BAD;
			sel_q    <= OSEL_ZERO;
			wr_q     <= 1'b0;
			wr_new_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					wr_new_q <= 1'b0;
					priority if (stat.bad) begin
						code_q  <= RC_BAD;
						sel_q   <= OSEL_ZERO;
						wr_q    <= 1'b0;
						state_q <= S_RESP;
					end else if (stat.op == OP_LOAD) begin
						code_q  <= RC_LOADED;
						sel_q   <= OSEL_REQ;
						wr_q    <= 1'b1;
						state_q <= S_RESP;
					end else if (stat.op == OP_READ) begin
						wr_q    <= 1'b0;
						state_q <= S_RD_WAIT;
					end else begin
						wr_q    <= 1'b0;
						state_q <= S_MV_OWN;
					end
				end
				S_RD_WAIT: begin
					code_q  <= RC_READ;
					sel_q   <= OSEL_OWN;
					state_q <= S_RESP;
				end
				S_MV_OWN: state_q <= S_MV_NEW;
				S_MV_NEW: state_q <= S_MV_BOX;
				S_MV_BOX: state_q <= S_MV_TEST;
				S_MV_TEST: begin
					if (stat.in_box) begin
						state_q <= S_SCAN;
					end else begin
						code_q  <= RC_OUTSIDE;
						sel_q   <= OSEL_OWN;
						state_q <= S_RESP;
					end
				end
				S_SCAN: begin
					if (stat.scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!stat.pipe_busy) begin
						if (stat.clash) begin
							code_q <= RC_OVERLAP;
							sel_q  <= OSEL_OWN;
						end else begin
							code_q   <= RC_ACCEPTED;
							sel_q    <= OSEL_NEW;
							wr_q     <= 1'b1;
							wr_new_q <= 1'b1;
						end
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/hsmc_dpath.sv
// hsmc_dpath: centre memory, move arithmetic, distance scan pipeline and result register
// depends on hsmc_pkg; driven by hsmc_ctrl through cmd_t and stat_t
module hsmc_dpath #(
	parameter int MAX_PARTICLES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hsmc_pkg::cfg_t     cfg,
	input  hsmc_pkg::cmd_t     cmd,
	output hsmc_pkg::stat_t    stat,
	input  logic [1:0]         in_op,
	input  logic [9:0]         in_idx,
	input  logic [95:0]        in_vals,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         out_code,
	output logic [95:0]        out_vals
);
	import hsmc_pkg::*;

	localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int CW = $clog2(MAX_PARTICLES + 1);
	localparam int WW = (CW > 11) ? CW : 11;

	// request registers
	logic [1:0]         op_q;
	logic [9:0]         idx_q;
	logic signed [31:0] req_q [NUM_AXES];
	logic               bad_q;
	logic [WW-1:0]      count_q;
	logic [WW-1:0]      count_eff;

	// centre memory, {z, y, x}
	logic [95:0]   mem [MAX_PARTICLES];
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] own_addr;
	logic [95:0]   rd_q;
	logic [95:0]   wr_data;

	// move arithmetic
	logic signed [17:0] frac_c   [NUM_AXES];
	logic signed [34:0] prod_q   [NUM_AXES];
	logic signed [34:0] step_w   [NUM_AXES];
	logic signed [31:0] own_q    [NUM_AXES];
	logic signed [33:0] new_q    [NUM_AXES];
	logic               inside_w;
	logic               inside_q;

	// scan pipeline
	logic [WW-1:0]      scan_n_q;
	logic               v_s1, skip_s1;
	logic               v_s2;
	logic [31:0]        abs_s2   [NUM_AXES];
	logic               far_s2;
	logic               v_s3;
	logic [63:0]        sq_s3    [NUM_AXES];
	logic               v_s4;
	logic [65:0]        sum_s4;
	logic [63:0]        limit_q;
	logic [31:0]        two_a;
	logic               clash_q;
	logic signed [34:0] diff_w   [NUM_AXES];
	logic [34:0]        mag_w    [NUM_AXES];
	logic               far_w;

	// result register
	logic               out_valid_q;
	logic [2:0]         out_code_q;
	logic [95:0]        out_vals_q;

	assign count_eff = (WW'(cfg.count) > WW'(MAX_PARTICLES)) ? WW'(MAX_PARTICLES)
	                                                           : WW'(cfg.count);
	assign own_addr  = AW'(idx_q);
	assign rd_addr   = cmd.rd_own ? own_addr : scan_n_q[AW-1:0];
	assign two_a     = {cfg.radius, 1'b0};

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			if ($signed(req_q[a]) > 32'sd65536) begin
				frac_c[a] = FRAC_ONE;
			end else if ($signed(req_q[a]) < -32'sd65536) begin
				frac_c[a] = -FRAC_ONE;
			end else begin
				frac_c[a] = req_q[a][17:0];
			end
			step_w[a] = (prod_q[a] + ROUND_HALF) >>> 16;
			wr_data[32*a +: 32] = cmd.wr_new ? new_q[a][31:0] : req_q[a];
		end
	end

	always_comb begin
		inside_w = 1'b1;
		for (int a = 0; a < NUM_AXES; a++) begin
			if (!(new_q[a] > 34'(signed'(cfg.box_low[a])) &&
			      new_q[a] < 34'(signed'(cfg.box_high[a])))) begin
				inside_w = 1'b0;
			end
		end
	end

	// per-axis difference and magnitude; a magnitude of 2^32 or more means far
	always_comb begin
		far_w = 1'b0;
		for (int a = 0; a < NUM_AXES; a++) begin
			diff_w[a] = 35'(new_q[a]) - 35'($signed(rd_q[32*a +: 32]));
			mag_w[a]  = diff_w[a][34] ? 35'(-diff_w[a]) : 35'(diff_w[a]);
			if (mag_w[a][34:32] != 3'd0) begin
				far_w = 1'b1;
			end
		end
	end

	// memory
	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[own_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		limit_q <= two_a * two_a;
		if (cmd.capture) begin
			op_q    <= in_op;
			idx_q   <= in_idx;
			count_q <= count_eff;
			bad_q   <= (in_op == OP_UNUSED) || (WW'(in_idx) >= count_eff);
			for (int a = 0; a < NUM_AXES; a++) begin
				req_q[a] <= in_vals[32*a +: 32];
			end
		end
		for (int a = 0; a < NUM_AXES; a++) begin
			prod_q[a] <= frac_c[a] * SIX_TENTHS;
			if (cmd.own_ld) begin
				own_q[a] <= rd_q[32*a +: 32];
			end
			if (cmd.new_ld) begin
				new_q[a] <= 34'(own_q[a]) + step_w[a][33:0];
			end
			abs_s2[a] <= mag_w[a][31:0];
			sq_s3[a]  <= abs_s2[a] * abs_s2[a];
		end
		if (cmd.box_ld) begin
			inside_q <= inside_w;
		end
		skip_s1 <= (scan_n_q == WW'(idx_q));
		far_s2  <= far_w;
		sum_s4  <= 66'(sq_s3[0]) + 66'(sq_s3[1]) + 66'(sq_s3[2]);
		if (cmd.out_ld) begin
			out_code_q <= cmd.code;
			unique case (cmd.sel)
				OSEL_ZERO: out_vals_q <= '0;
				OSEL_REQ:  out_vals_q <= {req_q[2], req_q[1], req_q[0]};
				OSEL_OWN:  out_vals_q <= {own_q[2], own_q[1], own_q[0]};
				OSEL_NEW:  out_vals_q <= {new_q[2][31:0], new_q[1][31:0], new_q[0][31:0]};
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_n_q    <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			clash_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.scan_clr) begin
				scan_n_q <= '0;
			end else if (cmd.scan_issue) begin
				scan_n_q <= scan_n_q + 1'b1;
			end
			v_s1 <= cmd.scan_issue;
			v_s2 <= v_s1 && !skip_s1;
			v_s3 <= v_s2 && !far_s2;
			v_s4 <= v_s3;
			if (cmd.scan_clr) begin
				clash_q <= 1'b0;
			end else if (v_s4 && (sum_s4 <= {2'b00, limit_q})) begin
				clash_q <= 1'b1;
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.bad       = bad_q;
		stat.op        = op_q;
		stat.in_box    = inside_q;
		stat.clash     = clash_q;
		stat.scan_last = (scan_n_q == count_q - 1'b1);
		stat.pipe_busy = v_s1 | v_s2 | v_s3 | v_s4;
		stat.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_code  = out_code_q;
	assign out_vals  = out_vals_q;

endmodule

### hw/rtl/hard_sphere_move_checker_unit.sv
// hard_sphere_move_checker_unit: top level of the hard sphere move checker
// depends on hsmc_pkg, hsmc_regs, hsmc_ctrl and hsmc_dpath
//
// channel     direction  handshake                  payload
// s_axis      in         tvalid / tready            tuser opcode, tdata index and x, y, z
// m_axis      out        tvalid / tready            tuser result code, tdata centre x, y, z
// apb         in         psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// one request at a time; a move runs a distance scan over the particle_count stored
// centres, reading one per cycle from the single read port of the centre memory
// the result sits in an output register, so the next request is taken while it waits
// arst_n clears the controller, pipeline valid bits and the output valid; the centre
// memory is not cleared and an entry is undefined until loaded
// a stall on m_axis holds the finished result and delays the load and write back of the next one
module hard_sphere_move_checker_unit #(
	parameter int MAX_PARTICLES = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	// request stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [111:0] s_axis_tdata,   // [9:0] particle_index, [41:10] value_x,
	                                     // [73:42] value_y, [105:74] value_z, zero pad
	input  logic [1:0]   s_axis_tuser,   // [1:0] opcode
	// result stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [95:0]  m_axis_tdata,   // [31:0] center_x, [63:32] center_y,
	                                     // [95:64] center_z
	output logic [2:0]   m_axis_tuser,   // [2:0] result_code
	// configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import hsmc_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	// no wait states on the config port
	assign pready = 1'b1;

	hsmc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// sequencing: decode, own centre fetch, step, box test, scan, drain, respond
	hsmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// memory, 0.6 step multipliers, squared distance pipeline, result register
	hsmc_dpath #(
		.MAX_PARTICLES (MAX_PARTICLES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.stat      (stat),
		.in_op     (s_axis_tuser),
		.in_idx    (s_axis_tdata[9:0]),
		.in_vals   (s_axis_tdata[105:10]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_code  (m_axis_tuser),
		.out_vals  (m_axis_tdata)
	);

	// a request in flight blocks the next one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request accepted while another is in flight");

	// a bad index or unused opcode answers with all-zero centres
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == RC_BAD)) |-> (m_axis_tdata == '0))
		else $error("bad index result carries nonzero centre");

	// the result register is only loaded into a free slot
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_ld) |-> (!m_axis_tvalid || m_axis_tready))
		else $error("pending result overwritten");

endmodule

### verif/sphere_table_checker.sv
// sphere_table_checker: watches the request, result and config channels of the
// hard sphere move checker, predicts every result and compares it; uses hsmc_pkg
`timescale 1ns / 1ps

module sphere_table_checker
	import hsmc_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [111:0] s_axis_tdata,   // [9:0] particle_index, [41:10] value_x,
	                                     // [73:42] value_y, [105:74] value_z
	input  logic [1:0]   s_axis_tuser,   // [1:0] opcode
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [95:0]  m_axis_tdata,   // [31:0] center_x, [63:32] center_y,
	                                     // [95:64] center_z
	input  logic [2:0]   m_axis_tuser,   // [2:0] result_code
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic         pready,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output int           mismatches,
	output int           outstanding
);

	typedef struct packed {
		rc_t         code;
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] cz;
	} centre_result_t;

	logic [30:0]        radius_q;
	logic signed [31:0] box_low [3];
	logic signed [31:0] box_high [3];
	logic [10:0]        count_q;

	logic [31:0] centre_x [TABLE_DEPTH];
	logic [31:0] centre_y [TABLE_DEPTH];
	logic [31:0] centre_z [TABLE_DEPTH];

	centre_result_t expected_centres [$];
	int             mismatch_total;

	// 0.6 times the clamped fraction, rounded half up to q16.16
	function automatic longint six_tenths_step(input logic [31:0] raw);
		longint f;
		f = longint'($signed(raw));
		if (f > 65536) f = 65536;
		if (f < -65536) f = -65536;
		return (f * 39322 + 32768) >>> 16;
	endfunction

	function automatic centre_result_t predict_step(input logic [1:0] op,
			input logic [9:0] idx, input logic [31:0] fx, input logic [31:0] fy,
			input logic [31:0] fz);
		centre_result_t r;
		int             live;
		longint         nx, ny, nz, mx, my, mz;
		logic [63:0]    two_a, lim;
		logic [65:0]    dist2;
		logic           clash;
		r.code = RC_BAD;
		r.cx = '0;
		r.cy = '0;
		r.cz = '0;
		live = (count_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_q);
		if (op == OP_UNUSED || idx >= live)
			return r;
		case (op)
			OP_LOAD: begin
				centre_x[idx] = fx;
				centre_y[idx] = fy;
				centre_z[idx] = fz;
				r.code = RC_LOADED;
			end
			OP_READ: begin
				r.code = RC_READ;
			end
			default: begin
				nx = longint'($signed(centre_x[idx])) + six_tenths_step(fx);
				ny = longint'($signed(centre_y[idx])) + six_tenths_step(fy);
				nz = longint'($signed(centre_z[idx])) + six_tenths_step(fz);
				if (!(nx > longint'(box_low[0]) && nx < longint'(box_high[0]) &&
						ny > longint'(box_low[1]) && ny < longint'(box_high[1]) &&
						nz > longint'(box_low[2]) && nz < longint'(box_high[2]))) begin
					r.code = RC_OUTSIDE;
				end else begin
					two_a = {32'd0, radius_q, 1'b0};
					lim = two_a * two_a;
					clash = 1'b0;
					for (int n = 0; n < live && !clash; n++) begin
						if (n != idx) begin
							mx = nx - longint'($signed(centre_x[n]));
							my = ny - longint'($signed(centre_y[n]));
							mz = nz - longint'($signed(centre_z[n]));
							if (mx < 0) mx = -mx;
							if (my < 0) my = -my;
							if (mz < 0) mz = -mz;
							// an axis gap of 2^32 or more can never overlap
							if (mx < 64'sd4294967296 && my < 64'sd4294967296 &&
									mz < 64'sd4294967296) begin
								dist2 = {2'b0, 64'(mx * mx)} + {2'b0, 64'(my * my)} +
									{2'b0, 64'(mz * mz)};
								if (dist2 <= {2'b0, lim})
									clash = 1'b1;
							end
						end
					end
					if (clash) begin
						r.code = RC_OVERLAP;
					end else begin
						centre_x[idx] = 32'(nx);
						centre_y[idx] = 32'(ny);
						centre_z[idx] = 32'(nz);
						r.code = RC_ACCEPTED;
					end
				end
			end
		endcase
		r.cx = centre_x[idx];
		r.cy = centre_y[idx];
		r.cz = centre_z[idx];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		centre_result_t want, got;
		if (!arst_n) begin
			radius_q = RADIUS_RST;
			for (int a = 0; a < 3; a++) begin
				box_low[a] = LOW_RST;
				box_high[a] = HIGH_RST;
			end
			count_q = COUNT_RST;
			expected_centres.delete();
			mismatch_total = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_RADIUS: radius_q = pwdata[30:0];
					REG_X_LOW:  box_low[0] = pwdata;
					REG_X_HIGH: box_high[0] = pwdata;
					REG_Y_LOW:  box_low[1] = pwdata;
					REG_Y_HIGH: box_high[1] = pwdata;
					REG_Z_LOW:  box_low[2] = pwdata;
					REG_Z_HIGH: box_high[2] = pwdata;
					REG_COUNT:  count_q = pwdata[10:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.code = rc_t'(m_axis_tuser);
				got.cx = m_axis_tdata[31:0];
				got.cy = m_axis_tdata[63:32];
				got.cz = m_axis_tdata[95:64];
				if (expected_centres.size() == 0) begin
					if (mismatch_total < 10)
						$display("%0t: result with nothing awaited: code %0d x %h y %h z %h",
							$realtime, got.code, got.cx, got.cy, got.cz);
					mismatch_total++;
				end else begin
					want = expected_centres.pop_front();
					if (got.code !== want.code || got.cx !== want.cx ||
							got.cy !== want.cy || got.cz !== want.cz) begin
						if (mismatch_total < 10)
							$display({"%0t: result differs: expected code %0d x %h y %h z %h,",
								" got code %0d x %h y %h z %h"}, $realtime, want.code,
								want.cx, want.cy, want.cz, got.code, got.cx, got.cy, got.cz);
						mismatch_total++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_centres.push_back(predict_step(s_axis_tuser, s_axis_tdata[9:0],
					s_axis_tdata[41:10], s_axis_tdata[73:42], s_axis_tdata[105:74]));
			mismatches <= mismatch_total;
			outstanding <= expected_centres.size();
		end
	end

endmodule

### verif/testbench.sv
// testbench: drives requests and register writes into hard_sphere_move_checker_unit
// and gives the verdict; depends on hsmc_pkg, the unit and sphere_table_checker
`timescale 1ns / 1ps

module testbench;
	import hsmc_pkg::*;

	localparam int TABLE_DEPTH = 1024;
	localparam int ONE = 65536;          // 1.0 in q16.16
	localparam int FIVE = 5 * ONE;
	localparam int STEP_ONE = 39322;     // move of a full +1 fraction

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [111:0] s_axis_tdata = '0;     // [9:0] particle_index, [41:10] value_x,
	                                     // [73:42] value_y, [105:74] value_z, zero pad
	logic [1:0]   s_axis_tuser = OP_LOAD; // [1:0] opcode
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [95:0]  m_axis_tdata;          // [31:0] center_x, [63:32] center_y,
	                                     // [95:64] center_z
	logic [2:0]   m_axis_tuser;          // [2:0] result_code
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [4:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	int mismatches;
	int outstanding;

	// percent of cycles in which the sender idles and the receiver stalls
	int send_idle_pct = 0;
	int ready_stall_pct = 0;

	// our own copy of the settings, used to aim the stimulus
	int     particles = COUNT_RST;
	longint box_lo [3] = '{0, 0, 0};
	longint box_hi [3] = '{655360, 655360, 655360};

	// entries loaded since reset; only these may be read, moved or scanned
	bit loaded [TABLE_DEPTH];

	hard_sphere_move_checker_unit #(
		.MAX_PARTICLES(TABLE_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	sphere_table_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// result side back-pressure, redrawn every cycle
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
	end

	// hard stop well beyond the slowest passing run
	initial begin
		#2000000;
		$display("hard_sphere_move_checker_unit: mismatch");
		$finish;
	end

	function automatic int live_count();
		return (particles > TABLE_DEPTH) ? TABLE_DEPTH : particles;
	endfunction

	// register write: setup cycle, access cycle, then idle
	task automatic write_reg(input logic [2:0] which, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (which)
			REG_X_LOW:  box_lo[0] = longint'($signed(value));
			REG_X_HIGH: box_hi[0] = longint'($signed(value));
			REG_Y_LOW:  box_lo[1] = longint'($signed(value));
			REG_Y_HIGH: box_hi[1] = longint'($signed(value));
			REG_Z_LOW:  box_lo[2] = longint'($signed(value));
			REG_Z_HIGH: box_hi[2] = longint'($signed(value));
			REG_COUNT:  particles = value[10:0];
			default: ;
		endcase
	endtask

	task automatic write_box(input int axis, input longint lo, input longint hi);
		case (axis)
			0: begin
				write_reg(REG_X_LOW, 32'(lo));
				write_reg(REG_X_HIGH, 32'(hi));
			end
			1: begin
				write_reg(REG_Y_LOW, 32'(lo));
				write_reg(REG_Y_HIGH, 32'(hi));
			end
			default: begin
				write_reg(REG_Z_LOW, 32'(lo));
				write_reg(REG_Z_HIGH, 32'(hi));
			end
		endcase
	endtask

	// one request; valid stays high after acceptance until the next call or a pause
	task automatic send(input logic [1:0] op, input logic [9:0] idx, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {6'd0, z, y, x, idx};
		do @(posedge clk); while (!s_axis_tready);
		if (op == OP_LOAD && idx < live_count())
			loaded[idx] = 1'b1;
	endtask

	// hold the sender until every awaited result is back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// idle point for register writes: every awaited result is back, so no request is in flight
	task automatic settle();
		drain_results();
		repeat (16) @(posedge clk);
	endtask

	// coordinate strictly inside the box on one axis, often close to a wall; random bits if no value fits
	function automatic logic [31:0] pick_coord(input int axis);
		longint span, off, edge_span;
		span = box_hi[axis] - box_lo[axis] - 1;
		if (span <= 0)
			return $urandom;
		off = longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % span;
		edge_span = (span < 98304) ? span : 98304;
		case ($urandom_range(0, 3))
			0: off = off % edge_span;
			1: off = span - 1 - (off % edge_span);
			default: ;
		endcase
		return 32'(box_lo[axis] + 1 + off);
	endfunction

	// move fraction: mostly within +-1, sometimes raw bits that need the clamp
	function automatic logic [31:0] pick_fraction();
		case ($urandom_range(0, 19))
			0, 1: return $urandom;
			2: return 32'(ONE);
			3: return -32'(ONE);
			default: return 32'($urandom_range(0, 2 * ONE)) - 32'(ONE);
		endcase
	endfunction

	// put every particle in use, or only those not yet loaded, somewhere inside the box
	task automatic place_all(input bit every);
		for (int n = 0; n < live_count(); n++)
			if (every || !loaded[n])
				send(OP_LOAD, 10'(n), pick_coord(0), pick_coord(1), pick_coord(2));
	endtask

	// mostly moves on a fully loaded table, with loads, reads and noise mixed in
	task automatic run_random(input int items);
		int          live, pick;
		logic [9:0]  idx;
		for (int i = 0; i < items; i++) begin
			live = live_count();
			pick = $urandom_range(0, 99);
			if (live == 0 || pick >= 90) begin
				// bad index or the unused opcode, with random payload
				idx = (live < TABLE_DEPTH && $urandom_range(0, 1) == 1) ?
					10'($urandom_range(live, TABLE_DEPTH - 1)) : 10'($urandom);
				send((live == 0) ? 2'($urandom) : OP_UNUSED, idx, $urandom, $urandom,
					$urandom);
			end else begin
				idx = 10'($urandom_range(0, live - 1));
				if (pick < 28)
					send(OP_LOAD, idx, pick_coord(0), pick_coord(1), pick_coord(2));
				else if (pick < 76)
					send(OP_MOVE, idx, pick_fraction(), pick_fraction(), pick_fraction());
				else
					send(OP_READ, idx, $urandom, $urandom, $urandom);
			end
			if ($urandom_range(0, 59) == 0)
				drain_results();
		end
	endtask

	initial begin
		longint lo, hi;
		int     items;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, one particle in a 10 unit box
		send(OP_LOAD, 10'd0, FIVE, FIVE, FIVE);
		send(OP_READ, 10'd0, '0, '0, '0);
		send(OP_MOVE, 10'd0, ONE, ONE, ONE);
		// fractions far beyond +-1 must clamp
		send(OP_MOVE, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000, '0);
		// smallest fractions and the rounding of their step
		send(OP_MOVE, 10'd0, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_0000);
		// bad index and unused opcode leave the table alone
		send(OP_READ, 10'd1, '0, '0, '0);
		send(OP_LOAD, 10'h3FF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		send(OP_UNUSED, 10'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// leaving the box through the high and the low wall
		send(OP_LOAD, 10'd0, 32'h0009_E666, FIVE, FIVE);
		send(OP_MOVE, 10'd0, ONE, '0, '0);
		send(OP_LOAD, 10'd0, 32'h0000_8000, FIVE, FIVE);
		send(OP_MOVE, 10'd0, -32'(ONE), '0, '0);
		// extreme centres, the new centre runs past 32 bits
		send(OP_LOAD, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000, '0);
		send(OP_READ, 10'd0, '0, '0, '0);
		send(OP_MOVE, 10'd0, ONE, -32'(ONE), '0);

		// two particles: distance exactly 2a overlaps, one lsb more does not
		settle();
		write_reg(REG_COUNT, 32'd2);
		send(OP_LOAD, 10'd0, FIVE, FIVE, FIVE);
		send(OP_LOAD, 10'd1, FIVE + 2 * ONE, FIVE, FIVE);
		send(OP_MOVE, 10'd0, '0, '0, '0);
		send(OP_LOAD, 10'd1, FIVE + 2 * ONE + 1, FIVE, FIVE);
		send(OP_MOVE, 10'd0, '0, '0, '0);

		// zero radius: only a coincident centre rejects
		settle();
		write_reg(REG_RADIUS, 32'd0);
		send(OP_LOAD, 10'd1, FIVE + STEP_ONE, FIVE, FIVE);
		send(OP_MOVE, 10'd0, ONE, '0, '0);
		send(OP_MOVE, 10'd0, '0, ONE, '0);

		// empty box in x: every move lands outside
		settle();
		write_reg(REG_X_LOW, HIGH_RST);
		send(OP_MOVE, 10'd1, '0, '0, '0);

		// random phases, each under its own settings and idle pattern
		for (int p = 0; p < 12; p++) begin
			settle();
			case (p % 4)
				0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
				1: begin send_idle_pct = 52; ready_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  ready_stall_pct = 52; end
				default: begin send_idle_pct = 18; ready_stall_pct = 18; end
			endcase
			items = 48;
			case (p)
				0: begin
					// radius and box back to their reset values, eight particles
					write_reg(REG_RADIUS, 32'(RADIUS_RST));
					for (int a = 0; a < 3; a++)
						write_box(a, 0, 10 * ONE);
					write_reg(REG_COUNT, 32'd8);
					place_all(1'b1);
				end
				1: begin
					write_reg(REG_RADIUS, 32'd0);
					write_reg(REG_COUNT, 32'd1);
					items = 40;
				end
				2: begin
					write_reg(REG_RADIUS, 32'd19661);
					for (int a = 0; a < 3; a++)
						write_box(a, -4 * ONE, 4 * ONE);
					write_reg(REG_COUNT, 32'd16);
					place_all(1'b1);
					items = 80;
				end
				3: begin
					// widest box, largest radius: overlaps are frequent
					write_reg(REG_RADIUS, 32'h7FFF_FFFF);
					for (int a = 0; a < 3; a++)
						write_box(a, -64'sd2147483648, 64'sd2147483647);
					write_reg(REG_COUNT, 32'd6);
					place_all(1'b1);
					items = 50;
				end
				4: begin
					// no particle in use: all indexes are bad
					write_reg(REG_RADIUS, 32'($urandom_range(0, 2 * ONE)));
					write_reg(REG_COUNT, 32'd0);
					items = 30;
				end
				5: begin
					// y low above y high: empty box
					write_reg(REG_RADIUS, 32'(ONE / 4));
					write_box(0, 0, 10 * ONE);
					write_box(1, 3 * ONE, -ONE);
					write_box(2, 0, 10 * ONE);
					write_reg(REG_COUNT, 32'd4);
					place_all(1'b0);
					items = 30;
				end
				6: begin
					// count above the table size: the top indexes are in use
					write_reg(REG_RADIUS, 32'(ONE / 2));
					for (int a = 0; a < 3; a++)
						write_box(a, 0, 64 * ONE);
					write_reg(REG_COUNT, 32'd2047);
					send(OP_LOAD, 10'h3FF, pick_coord(0), pick_coord(1), pick_coord(2));
					send(OP_READ, 10'h3FF, '0, '0, '0);
					send(OP_LOAD, 10'd700, pick_coord(0), pick_coord(1), pick_coord(2));
					send(OP_READ, 10'd700, '0, '0, '0);
					items = 0;
				end
				7: begin
					write_reg(REG_RADIUS, 32'd0);
					write_reg(REG_COUNT, 32'd16);
					items = 40;
				end
				default: begin
					// random radius, box and a small population
					write_reg(REG_RADIUS, 32'($urandom_range(0, 2 * ONE)));
					for (int a = 0; a < 3; a++) begin
						lo = -longint'($urandom_range(0, 12)) * ONE -
							longint'($urandom_range(0, ONE - 1));
						hi = lo + longint'($urandom_range(3, 16)) * ONE +
							longint'($urandom_range(0, ONE - 1));
						write_box(a, lo, hi);
					end
					write_reg(REG_COUNT, 32'($urandom_range(2, 12)));
					place_all(1'b1);
				end
			endcase
			run_random(items);
		end

		// wait out every result, then give the verdict
		drain_results();
		repeat (32) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("hard_sphere_move_checker_unit: match");
		else
			$display("hard_sphere_move_checker_unit: mismatch");
		$finish;
	end

endmodule

### sim.f
hw/rtl/hsmc_pkg.sv
hw/rtl/hsmc_regs.sv
hw/rtl/hsmc_ctrl.sv
hw/rtl/hsmc_dpath.sv
hw/rtl/hard_sphere_move_checker_unit.sv
verif/sphere_table_checker.sv
verif/testbench.sv
